>>> design/stream_find_replace_all_defines.svh
// Assertion macros for the stream find/replace block.
// Used by the checker only; no dependencies.
`ifndef STREAM_FIND_REPLACE_ALL_DEFINES_SVH
`define STREAM_FIND_REPLACE_ALL_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfr assertion failed");

// Next-cycle implication, disabled while in reset.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfr assertion failed");

`endif

>>> design/sfr_pkg.sv
// Package for the stream find/replace block: sizes, register indexes,
// transaction payload types and internal control structs. No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int MAX_SEARCH_BYTES  = 8;
	localparam int MAX_REPLACE_BYTES = 8;
	localparam int MAX_RUN_BYTES     = (MAX_SEARCH_BYTES > MAX_REPLACE_BYTES) ?
		MAX_SEARCH_BYTES : MAX_REPLACE_BYTES;

	localparam int CNT_W     = $clog2(MAX_SEARCH_BYTES + 1);
	localparam int RUN_CNT_W = $clog2(MAX_RUN_BYTES + 1);
	localparam int LEN_W     = 4;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_SEARCH_PATTERN     = 2'd0;
	localparam logic [IDX_W-1:0] REG_SEARCH_LENGTH      = 2'd1;
	localparam logic [IDX_W-1:0] REG_REPLACEMENT_TEXT   = 2'd2;
	localparam logic [IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       last_of_run;
		logic       text_done;
	} out_item_t;

	typedef struct packed {
		logic [MAX_SEARCH_BYTES-1:0][7:0]  pattern;
		logic [CNT_W-1:0]                  search_len;
		logic [MAX_REPLACE_BYTES-1:0][7:0] replacement;
		logic [RUN_CNT_W-1:0]              replace_len;
	} match_cfg_t;

	typedef struct packed {
		logic [MAX_RUN_BYTES-1:0][7:0] bytes;
		logic [RUN_CNT_W-1:0]          count;
		logic                          present;
		logic                          eot;
	} run_t;

endpackage

>>> design/stream_find_replace_all.sv
// Stream find/replace-all top level: input register, pending window, result buffer.
// An accepted transaction waits in the input register; its results are presented from
// the result buffer. Throughput: one transaction per cycle while each yields at most
// one result and the output does not stall; one yielding more stalls the input until
// its last result is taken, as does any output stall. Reset restores the register defaults and
// empties the input register, window and result buffer.
`timescale 1ns / 1ps

module stream_find_replace_all (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sfr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sfr_pkg::out_item_t            out_data,
	input  logic                          cfg_wr_en,
	input  logic [sfr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]     cfg_data
);
	import sfr_pkg::*;

	logic [CFG_W-1:0] pattern_q;
	logic [LEN_W-1:0] search_len_q;
	logic [CFG_W-1:0] replacement_q;
	logic [LEN_W-1:0] replace_len_q;

	logic       valid_s1;
	in_item_t   item_s1;

	logic [7:0]           obuf_q [MAX_RUN_BYTES];
	logic [RUN_CNT_W-1:0] ocnt_q;
	logic                 present_q;
	logic                 eot_q;

	match_cfg_t cfg;
	run_t       run;
	logic       out_take;
	logic       buf_free;
	logic       advance;
	logic       clear;

	always_comb begin
		cfg.pattern     = pattern_q[MAX_SEARCH_BYTES*8-1:0];
		cfg.replacement = replacement_q[MAX_REPLACE_BYTES*8-1:0];
		if (search_len_q == '0) begin
			cfg.search_len = CNT_W'(1);
		end else if (search_len_q > LEN_W'(MAX_SEARCH_BYTES)) begin
			cfg.search_len = CNT_W'(MAX_SEARCH_BYTES);
		end else begin
			cfg.search_len = CNT_W'(search_len_q);
		end
		if (replace_len_q > LEN_W'(MAX_REPLACE_BYTES)) begin
			cfg.replace_len = RUN_CNT_W'(MAX_REPLACE_BYTES);
		end else begin
			cfg.replace_len = RUN_CNT_W'(replace_len_q);
		end
	end

	assign clear     = cfg_wr_en && (cfg_index == REG_SEARCH_LENGTH);
	assign out_valid = ocnt_q != '0;
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (ocnt_q == '0) || ((ocnt_q == RUN_CNT_W'(1)) && !out_stall);
	assign advance   = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !advance;

	assign out_data.out_byte     = obuf_q[0];
	assign out_data.byte_present = present_q;
	assign out_data.last_of_run  = ocnt_q == RUN_CNT_W'(1);
	assign out_data.text_done    = eot_q && (ocnt_q == RUN_CNT_W'(1));

	sfr_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.clear   (clear),
		.item    (item_s1),
		.cfg     (cfg),
		.run     (run)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			search_len_q  <= LEN_W'(1);
			replacement_q <= '0;
			replace_len_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SEARCH_PATTERN:     pattern_q     <= cfg_data;
				REG_SEARCH_LENGTH:      search_len_q  <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_TEXT:   replacement_q <= cfg_data;
				REG_REPLACEMENT_LENGTH: replace_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q    <= '0;
			present_q <= 1'b0;
			eot_q     <= 1'b0;
		end else if (advance && (run.count != '0)) begin
			ocnt_q    <= run.count;
			present_q <= run.present;
			eot_q     <= run.eot;
		end else if (out_take) begin
			ocnt_q <= ocnt_q - RUN_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (run.count != '0)) begin
			for (int i = 0; i < MAX_RUN_BYTES; i++) begin
				obuf_q[i] <= run.bytes[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < MAX_RUN_BYTES - 1; i++) begin
				obuf_q[i] <= obuf_q[i + 1];
			end
		end
	end

endmodule

>>> design/sfr_window.sv
// Pending window of the stream find/replace block: holds the bytes that may
// still start a match, compares against the pattern and builds the run of
// bytes one transaction produces. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               clear,
	input  sfr_pkg::in_item_t  item,
	input  sfr_pkg::match_cfg_t cfg,
	output sfr_pkg::run_t      run
);
	import sfr_pkg::*;

	logic [7:0]       win_q [MAX_SEARCH_BYTES];
	logic [CNT_W-1:0] count_q;

	logic [7:0]       ext     [MAX_SEARCH_BYTES];
	logic [7:0]       shifted [MAX_SEARCH_BYTES];
	logic [CNT_W-1:0] cnt_next;
	logic             full;
	logic             equal;
	logic             match;

	always_comb begin
		for (int i = 0; i < MAX_SEARCH_BYTES; i++) begin
			ext[i] = (count_q == CNT_W'(i)) ? item.text_byte : win_q[i];
		end
		for (int i = 0; i < MAX_SEARCH_BYTES - 1; i++) begin
			shifted[i] = ext[i + 1];
		end
		shifted[MAX_SEARCH_BYTES - 1] = ext[MAX_SEARCH_BYTES - 1];
		cnt_next = count_q + CNT_W'(1);
		full     = cnt_next >= cfg.search_len;
		equal    = 1'b1;
		for (int i = 0; i < MAX_SEARCH_BYTES; i++) begin
			if ((CNT_W'(i) < cfg.search_len) && (ext[i] != cfg.pattern[i])) begin
				equal = 1'b0;
			end
		end
		match = full && equal;
	end

	always_comb begin
		for (int i = 0; i < MAX_RUN_BYTES; i++) begin
			run.bytes[i] = 8'd0;
			if (match) begin
				if (i < MAX_REPLACE_BYTES) begin
					run.bytes[i] = cfg.replacement[i];
				end
			end else if (i < MAX_SEARCH_BYTES) begin
				run.bytes[i] = ext[i];
			end
		end
		if (match) begin
			run.count = cfg.replace_len;
		end else if (item.end_of_text) begin
			run.count = RUN_CNT_W'(cnt_next);
		end else if (full) begin
			run.count = RUN_CNT_W'(1);
		end else begin
			run.count = '0;
		end
		run.present = 1'b1;
		run.eot     = item.end_of_text;
		if (item.end_of_text && (run.count == '0)) begin
			run.count    = RUN_CNT_W'(1);
			run.present  = 1'b0;
			run.bytes[0] = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (advance) begin
			if (item.end_of_text || match) begin
				count_q <= '0;
			end else if (full) begin
				count_q <= count_q;
			end else begin
				count_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MAX_SEARCH_BYTES; i++) begin
				win_q[i] <= full ? shifted[i] : ext[i];
			end
		end
	end

endmodule

>>> design/sfr_checker.sv
// Port-level checker for the stream find/replace block, bound to the top level.
// Depends on sfr_pkg and stream_find_replace_all_defines.svh.
`timescale 1ns / 1ps
`include "stream_find_replace_all_defines.svh"

module sfr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input sfr_pkg::out_item_t out_data
);
	import sfr_pkg::*;

	`SFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`SFR_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid && out_data.text_done, out_data.last_of_run)
	`SFR_ASSERT_NOW(a_empty_only_at_end, clk, arst_n, out_valid && !out_data.byte_present, out_data.text_done)
	`SFR_ASSERT_NEXT(a_run_no_gap, clk, arst_n, out_valid && !out_stall && !out_data.last_of_run, out_valid)

endmodule

bind stream_find_replace_all sfr_checker u_sfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> verif/tb_stream_find_replace_all.sv
// Testbench for stream_find_replace_all: directed and random texts checked against an
// in-bench find/replace predictor, with random idling and a long output hold-off.
// Depends on sfr_pkg and the stream_find_replace_all top level.
`timescale 1ns / 1ps

module tb_stream_find_replace_all;
	import sfr_pkg::*;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int DRAIN_CYCLES     = 16;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_TARGET    = 210;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               cfg_wr_en;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	logic [CFG_W-1:0]   cfg_pattern;
	logic [3:0]         cfg_search_len;
	logic [CFG_W-1:0]   cfg_replacement;
	logic [3:0]         cfg_replace_len;
	logic [7:0]         pending_bytes [MAX_SEARCH_BYTES];
	int                 pending_fill;

	out_item_t          expected_bytes [$];
	out_item_t          want;
	int                 mismatches;
	int                 items_sent;
	int                 cycle_count;
	bit                 src_pacing;
	bit                 sink_pacing;
	bit                 long_hold_req;

	stream_find_replace_all dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** stream_find_replace_all: FAILED **");
			$finish;
		end
	end

	function automatic int eff_search_len();
		if (cfg_search_len == 4'd0)
			return 1;
		if (cfg_search_len > MAX_SEARCH_BYTES)
			return MAX_SEARCH_BYTES;
		return int'(cfg_search_len);
	endfunction

	function automatic int eff_replace_len();
		if (cfg_replace_len > MAX_REPLACE_BYTES)
			return MAX_REPLACE_BYTES;
		return int'(cfg_replace_len);
	endfunction

	task automatic predict_rewrite(input logic [7:0] text_byte, input bit at_end);
		int slen;
		int rlen;
		int n;
		bit hit;
		out_item_t run [MAX_RUN_BYTES];
		slen = eff_search_len();
		rlen = eff_replace_len();
		n = 0;
		if (pending_fill < MAX_SEARCH_BYTES) begin
			pending_bytes[pending_fill] = text_byte;
			pending_fill++;
		end
		if (pending_fill >= slen) begin
			hit = 1'b1;
			for (int i = 0; i < slen; i++)
				if (pending_bytes[i] != cfg_pattern[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rlen; i++) begin
					run[n] = '{cfg_replacement[8*i +: 8], 1'b1, 1'b0, 1'b0};
					n++;
				end
				pending_fill = 0;
			end else begin
				run[n] = '{pending_bytes[0], 1'b1, 1'b0, 1'b0};
				n++;
				for (int i = 0; i < MAX_SEARCH_BYTES - 1; i++)
					pending_bytes[i] = pending_bytes[i+1];
				pending_fill--;
			end
		end
		if (at_end) begin
			for (int i = 0; i < pending_fill; i++) begin
				run[n] = '{pending_bytes[i], 1'b1, 1'b0, 1'b0};
				n++;
			end
			pending_fill = 0;
			if (n == 0) begin
				run[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
				n = 1;
			end
			run[n-1].text_done = 1'b1;
		end
		if (n > 0)
			run[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			expected_bytes.insert(expected_bytes.size(), run[i]);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, out_data);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %h actual %h",
						$time, want.out_byte, out_data.out_byte);
					mismatches++;
				end
				if (out_data.byte_present !== want.byte_present) begin
					$display("%0t: byte_present expected %b actual %b",
						$time, want.byte_present, out_data.byte_present);
					mismatches++;
				end
				if (out_data.last_of_run !== want.last_of_run) begin
					$display("%0t: last_of_run expected %b actual %b",
						$time, want.last_of_run, out_data.last_of_run);
					mismatches++;
				end
				if (out_data.text_done !== want.text_done) begin
					$display("%0t: text_done expected %b actual %b",
						$time, want.text_done, out_data.text_done);
					mismatches++;
				end
			end
		end
	end

	initial begin : sink_pacing_proc
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (out_valid && !out_stall) begin
				stall_left = sink_pacing ? $urandom_range(0, 16) : 0;
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] text_byte, input bit at_end);
		int gap;
		in_valid <= 1'b1;
		in_data <= '{text_byte: text_byte, end_of_text: at_end};
		do @(posedge clk); while (in_stall);
		predict_rewrite(text_byte, at_end);
		items_sent++;
		gap = src_pacing ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SEARCH_PATTERN: cfg_pattern = value;
			REG_SEARCH_LENGTH: begin
				cfg_search_len = value[3:0];
				pending_fill = 0;
			end
			REG_REPLACEMENT_TEXT: cfg_replacement = value;
			REG_REPLACEMENT_LENGTH: cfg_replace_len = value[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();
	endtask

	task automatic test_find_replace_basic();
		write_reg(REG_SEARCH_PATTERN, 64'h0000_0000_0063_6261);
		write_reg(REG_SEARCH_LENGTH, 64'd3);
		write_reg(REG_REPLACEMENT_TEXT, 64'h0000_0000_0000_5958);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h64, 1'b1);
		wait_idle();
	endtask

	task automatic test_length_saturation();
		write_reg(REG_SEARCH_PATTERN, {CFG_W{1'b1}});
		write_reg(REG_SEARCH_LENGTH, 64'd0);
		write_reg(REG_REPLACEMENT_TEXT, 64'h0123_4567_89AB_CDEF);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_idle();
		write_reg(REG_SEARCH_LENGTH, 64'd15);
		write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
		repeat (8) send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();
	endtask

	task automatic test_search_length_rewrite();
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		wait_idle();
		write_reg(REG_SEARCH_LENGTH, 64'd1);
		send_byte(8'h7E, 1'b1);
		wait_idle();
	endtask

	task automatic random_setup();
		logic [3:0] slen_raw;
		logic [3:0] rlen_raw;
		logic [CFG_W-1:0] pattern;
		case ($urandom_range(0, 7))
			0: slen_raw = 4'd0;
			1: slen_raw = 4'($urandom_range(9, 15));
			2: slen_raw = 4'd8;
			default: slen_raw = 4'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 7))
			0: rlen_raw = 4'd0;
			1: rlen_raw = 4'($urandom_range(9, 15));
			2: rlen_raw = 4'd8;
			default: rlen_raw = 4'($urandom_range(1, 4));
		endcase
		pattern = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			pattern = {8{8'($urandom)}};
		write_reg(REG_SEARCH_PATTERN, pattern);
		write_reg(REG_SEARCH_LENGTH, {$urandom, 28'($urandom), slen_raw});
		write_reg(REG_REPLACEMENT_TEXT, {$urandom, $urandom});
		write_reg(REG_REPLACEMENT_LENGTH, {$urandom, 28'($urandom), rlen_raw});
	endtask

	task automatic send_random_text(input int max_len);
		logic [7:0] text [$];
		int target;
		int slen;
		int pick;
		int pos;
		slen = eff_search_len();
		target = $urandom_range(1, max_len);
		while (text.size() < target) begin
			pick = $urandom_range(0, 7);
			if (pick < 3) begin
				for (int j = 0; j < slen; j++)
					text.insert(text.size(), cfg_pattern[8*j +: 8]);
				if (pick == 0)
					text[text.size()-1] = text[text.size()-1] ^ 8'(1 << $urandom_range(0, 7));
			end else if (pick < 6) begin
				pos = $urandom_range(0, slen - 1);
				text.insert(text.size(), cfg_pattern[8*pos +: 8]);
			end else begin
				text.insert(text.size(), 8'($urandom));
			end
		end
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
	endtask

	task automatic test_random_texts();
		while (items_sent < RANDOM_TARGET) begin
			wait_idle();
			src_pacing = ($urandom_range(0, 3) != 0);
			sink_pacing = ($urandom_range(0, 3) != 0);
			random_setup();
			repeat (3) send_random_text(16);
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		src_pacing = 1'b0;
		sink_pacing = 1'b0;
		write_reg(REG_SEARCH_PATTERN, 64'h0000_0000_0000_00A5);
		write_reg(REG_SEARCH_LENGTH, 64'd1);
		write_reg(REG_REPLACEMENT_TEXT, {$urandom, $urandom});
		write_reg(REG_REPLACEMENT_LENGTH, 64'd8);
		long_hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_byte(($urandom_range(0, 1) == 0) ? 8'hA5 : 8'($urandom), i == 29);
		wait_idle();
		sink_pacing = 1'b1;
		for (int i = 0; i < 6; i++)
			send_byte(8'hA5, i == 5);
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cfg_pattern = '0;
		cfg_search_len = 4'd1;
		cfg_replacement = '0;
		cfg_replace_len = 4'd0;
		pending_fill = 0;
		mismatches = 0;
		items_sent = 0;
		cycle_count = 0;
		long_hold_req = 1'b0;
		src_pacing = 1'b1;
		sink_pacing = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_find_replace_basic();
		test_length_saturation();
		test_search_length_rewrite();
		test_random_texts();
		test_backpressure();
		if (mismatches == 0) begin
			$display("** stream_find_replace_all: PASSED **");
		end else begin
			$display("** stream_find_replace_all: FAILED **");
		end
		$finish;
	end

endmodule
